@@ src/assert_macros.svh @@
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge of clk, off while rst is high.
`define GAU_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// A stalled signal must hold its value into the next cycle.
`define GAU_ASSERT_HOLD(label, stall, sig, msg) \
  `GAU_ASSERT(label, (stall) |=> $stable(sig), msg)

`endif

@@ src/gau_pkg.sv @@
// Shared widths and aggregate mode codes for the group aggregate unit.
package gau_pkg;

  localparam int DATA_W = 32;
  localparam int MODE_W = 3;
  localparam int BIT_W  = $clog2(DATA_W);

  localparam logic [MODE_W-1:0] MODE_NONE  = 3'd0;
  localparam logic [MODE_W-1:0] MODE_SUM   = 3'd1;
  localparam logic [MODE_W-1:0] MODE_COUNT = 3'd2;
  localparam logic [MODE_W-1:0] MODE_MAX   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_MIN   = 3'd4;
  localparam logic [MODE_W-1:0] MODE_AVG   = 3'd5;

  typedef logic [DATA_W-1:0] data_t;
  typedef logic [MODE_W-1:0] mode_t;

endpackage

@@ src/group_aggregate_unit.sv @@
// Running group aggregate (sum, count, max, min, average) over a 32-bit fact column.
//
//  channel | signals                                   | direction
//  in      | in_valid, in_ready, fact_value, group_start | into block
//  out     | out_valid, out_ready, aggregate_value     | out of block
//  cfg     | cfg_valid, cfg_ready, aggregate_mode      | into block
//
// Every item passes through an accept state, a setup state (product for
// the average), a bit-serial pass over the 32 bits and a write-back state.
// The bit-serial pass uses the serial adder/comparator, or the
// radix-2 restoring divider in average mode.
// An item in average mode whose count is zero skips the serial pass.
// The output register holds a result while out_ready is low; the next item
// is taken meanwhile and waits in the write-back state.
// rst clears the aggregate state, the mode and the in and out handshakes.
module group_aggregate_unit (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [gau_pkg::DATA_W-1:0]     fact_value,
  input  logic                           group_start,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [gau_pkg::DATA_W-1:0]     aggregate_value,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [gau_pkg::MODE_W-1:0]     aggregate_mode
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_PREP = 2'd1;
  localparam logic [1:0] ST_RUN  = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0]               state;
  gau_pkg::mode_t           mode;
  gau_pkg::data_t           acc;
  gau_pkg::data_t           cnt;
  logic                     has_value;

  gau_pkg::data_t           opa;
  gau_pkg::data_t           opb;
  gau_pkg::data_t           res;
  logic [gau_pkg::DATA_W-1:0] rem;
  logic [gau_pkg::DATA_W:0] den;
  logic                     carry;
  logic                     gt;
  logic                     lt;
  logic [gau_pkg::BIT_W-1:0] bitcnt;

  logic                     b_bit;
  logic                     s_bit;
  logic                     c_next;
  logic [gau_pkg::DATA_W:0] rem_shift;
  logic [gau_pkg::DATA_W:0] rem_diff;
  logic                     q_bit;
  gau_pkg::data_t           prod;
  gau_pkg::data_t           result;
  gau_pkg::data_t           cnt_next;
  logic                     load_out;

  assign in_ready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign load_out  = (state == ST_DONE) && (!out_valid || out_ready);

  // serial add: sum takes the value bit, count adds one at the low bit
  always_comb begin
    b_bit  = (mode == gau_pkg::MODE_SUM) ? opb[0] : (bitcnt == '0);
    s_bit  = opa[0] ^ b_bit ^ carry;
    c_next = (opa[0] & b_bit) | (opa[0] & carry) | (b_bit & carry);
  end

  // one restoring division step, numerator leaves opb at the top
  always_comb begin
    rem_shift = {rem, opb[gau_pkg::DATA_W-1]};
    rem_diff  = rem_shift - den;
    q_bit     = (rem_shift >= den);
  end

  assign prod = acc * cnt;

  always_comb begin
    unique case (mode)
      gau_pkg::MODE_SUM,
      gau_pkg::MODE_COUNT: result = res;
      gau_pkg::MODE_MAX:   result = gt ? opb : opa;
      gau_pkg::MODE_MIN:   result = (!has_value || lt) ? opb : opa;
      gau_pkg::MODE_AVG:   result = opb;
      default:             result = opa;
    endcase
  end

  always_comb begin
    if (cnt == '0) begin
      cnt_next = gau_pkg::DATA_W'(1);
    end else if (cnt == '1) begin
      cnt_next = cnt;
    end else begin
      cnt_next = cnt + gau_pkg::DATA_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      mode      <= gau_pkg::MODE_NONE;
      acc       <= '0;
      cnt       <= '0;
      has_value <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        mode <= aggregate_mode;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            // a group start clears the state before the value is folded in
            opa <= group_start ? '0 : acc;
            opb <= fact_value;
            if (group_start) begin
              acc       <= '0;
              cnt       <= '0;
              has_value <= 1'b0;
            end
            state <= ST_PREP;
          end
        end
        ST_PREP: begin
          carry  <= 1'b0;
          gt     <= 1'b0;
          lt     <= 1'b0;
          rem    <= '0;
          bitcnt <= '0;
          den    <= {1'b0, cnt} + (gau_pkg::DATA_W+1)'(1);
          if (mode == gau_pkg::MODE_AVG) begin
            if (cnt == '0) begin
              state <= ST_DONE;
            end else begin
              opb   <= prod + opb;
              state <= ST_RUN;
            end
          end else begin
            state <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (mode == gau_pkg::MODE_AVG) begin
            rem <= q_bit ? rem_diff[gau_pkg::DATA_W-1:0] : rem_shift[gau_pkg::DATA_W-1:0];
            opb <= {opb[gau_pkg::DATA_W-2:0], q_bit};
          end else begin
            // rotate so both operands are back in place after the last step
            opa   <= {opa[0], opa[gau_pkg::DATA_W-1:1]};
            opb   <= {opb[0], opb[gau_pkg::DATA_W-1:1]};
            res   <= {s_bit, res[gau_pkg::DATA_W-1:1]};
            carry <= c_next;
            if (opa[0] != opb[0]) begin
              gt <= opb[0];
              lt <= opa[0];
            end
          end
          bitcnt <= bitcnt + gau_pkg::BIT_W'(1);
          if (bitcnt == '1) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (load_out) begin
            acc             <= result;
            aggregate_value <= result;
            has_value       <= 1'b1;
            if (mode == gau_pkg::MODE_AVG) begin
              cnt <= cnt_next;
            end
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

@@ src/gau_checker.sv @@
// Port-level checks for the group aggregate unit, bound into every group_aggregate_unit instance.
`include "assert_macros.svh"

module gau_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [gau_pkg::DATA_W-1:0] aggregate_value,
  input logic                       cfg_ready
);

  `GAU_ASSERT_HOLD(a_out_hold, out_valid && !out_ready, aggregate_value, "result changed while stalled")
  `GAU_ASSERT(a_out_stay, (out_valid && !out_ready) |=> out_valid, "result dropped while stalled")
  `GAU_ASSERT(a_busy_after_accept, (in_valid && in_ready) |=> !in_ready, "item taken while busy")
  `GAU_ASSERT(a_result_from_work, $rose(out_valid) |-> $past(!in_ready), "result with no item in work")
  `GAU_ASSERT(a_cfg_open, cfg_ready, "config port closed")

endmodule

bind group_aggregate_unit gau_checker u_gau_checker (
  .clk             (clk),
  .rst             (rst),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .aggregate_value (aggregate_value),
  .cfg_ready       (cfg_ready)
);
